[hdl/ffra_pkg.sv]
// shared constants, codes and interface types of the first-fit region allocator
`default_nettype none
package ffra_pkg;
   localparam int MAX_BLOCKS = 32;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = 16;
   localparam int PAGES_W    = 17;
   localparam int NEED_W     = 33 - PAGE_SHIFT;
   localparam int RBYTES_W   = 29;
   localparam logic [31:0]      BASE_RESET   = 32'h1000_0000;
   localparam logic [PAGES_W-1:0] REGION_MAX = 17'd65536;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_REINIT = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_NOMEM   = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [7:0] CSR_BASE   = 8'd0;
   localparam logic [7:0] CSR_REGION = 8'd1;

   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_LOAD      = 4'd1;
   localparam logic [3:0] CMD_STEP      = 4'd2;
   localparam logic [3:0] CMD_ALLOC     = 4'd3;
   localparam logic [3:0] CMD_QUERY     = 4'd4;
   localparam logic [3:0] CMD_SAVE_FREE = 4'd5;
   localparam logic [3:0] CMD_SAVE_NEXT = 4'd6;
   localparam logic [3:0] CMD_MERGE     = 4'd7;
   localparam logic [3:0] CMD_REINIT    = 4'd8;
   localparam logic [3:0] CMD_RESULT    = 4'd9;

   typedef struct packed {
      logic [3:0]       code;
      logic [CNT_W-1:0] idx;
      logic [2:0]       status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       req_zero;
      logic       tgt_null;
      logic       match;
      logic       at_end;
      logic       split_needed;
      logic       table_full;
      logic       rsp_busy;
   } stat_type;
endpackage
`default_nettype wire

[hdl/ffra_ctrl.sv]
// controller state machine sequencing scan, split and merge steps
`default_nettype none
module ffra_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire ffra_pkg::stat_type stat,
   output ffra_pkg::cmd_type      cmd
);
   import ffra_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FNEXT  = 3'd3;
   localparam logic [2:0] S_FMERGE = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [2:0]       code_ff, code_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      code_in  = code_ff;
      cmd      = '{code: CMD_NONE, idx: idx_ff, status: code_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.code = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in  = '0;
            code_in = ST_OK;
            priority if (stat.op == OP_REINIT) begin
               cmd.code = CMD_REINIT;
               state_in = S_FIN;
            end else if (stat.op == OP_ALLOC && stat.req_zero) begin
               code_in  = ST_ZERO;
               state_in = S_FIN;
            end else if (stat.op != OP_ALLOC && stat.tgt_null) begin
               code_in  = ST_INVALID;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (stat.at_end) begin
               code_in  = (stat.op == OP_ALLOC) ? ST_NOMEM : ST_INVALID;
               state_in = S_FIN;
            end else if (stat.match) begin
               priority if (stat.op == OP_ALLOC) begin
                  if (stat.split_needed && stat.table_full) begin
                     code_in = ST_FULL;
                  end else begin
                     cmd.code = CMD_ALLOC;
                  end
                  state_in = S_FIN;
               end else if (stat.op == OP_QUERY) begin
                  cmd.code = CMD_QUERY;
                  state_in = S_FIN;
               end else begin
                  cmd.code = CMD_SAVE_FREE;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_FNEXT;
               end
            end else begin
               cmd.code = CMD_STEP;
               idx_in   = idx_ff + 1'b1;
            end
         end
         S_FNEXT: begin
            cmd.code = CMD_SAVE_NEXT;
            state_in = S_FMERGE;
         end
         S_FMERGE: begin
            cmd.code = CMD_MERGE;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!stat.rsp_busy) begin
               cmd.code = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         code_ff  <= code_in;
      end
   end

   a_fin_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_RESULT |=> state_ff == S_IDLE)
      else $error("result beat not followed by idle");
   a_load_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_LOAD |-> req_tvalid && req_tready)
      else $error("load without accepted beat");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CNT_W'(MAX_BLOCKS))
      else $error("scan index past table");
endmodule
`default_nettype wire

[hdl/ffra_datapath.sv]
// block table, request latch, match logic, totals and response register
`default_nettype none
module ffra_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ffra_pkg::cmd_type  cmd,
   output ffra_pkg::stat_type      stat,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [31:0]        req_bytes,
   input  wire logic [31:0]        req_target,
   input  wire logic               csr_write,
   input  wire logic [7:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [2:0]              rsp_status,
   output logic [31:0]             rsp_address,
   output logic [ffra_pkg::RBYTES_W-1:0] rsp_bytes,
   output logic [31:0]             rsp_alloc_total,
   output logic [31:0]             rsp_freed_total
);
   import ffra_pkg::*;

   logic [PAGE_W-1:0]  start_ff [MAX_BLOCKS];
   logic [PAGE_W-1:0]  start_in [MAX_BLOCKS];
   logic [PAGES_W-1:0] pages_ff [MAX_BLOCKS];
   logic [PAGES_W-1:0] pages_in [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] free_ff, free_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [31:0]        base_ff, alloc_tot_ff, alloc_tot_in, freed_tot_ff, freed_tot_in;
   logic [PAGES_W-1:0] region_ff;
   logic [1:0]         op_ff;
   logic [NEED_W-1:0]  need_ff;
   logic [31:0]        tgt_ff;
   logic               zero_ff;
   logic [31:0]        raddr_ff, raddr_in;
   logic [RBYTES_W-1:0] rbytes_ff, rbytes_in;
   logic [IDX_W-1:0]   found_ff;
   logic [PAGES_W-1:0] found_pages_ff, prev_pages_ff, next_pages_ff;
   logic               prev_free_ff, next_free_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [31:0]        rsp_addr_ff, rsp_atot_ff, rsp_ftot_ff;
   logic [RBYTES_W-1:0] rsp_bytes_ff;

   logic [IDX_W-1:0]   ridx;
   logic [PAGE_W-1:0]  cur_start;
   logic [PAGES_W-1:0] cur_pages;
   logic               cur_free;
   logic [31:0]        cur_addr, need_bytes;
   logic [PAGES_W-1:0] eff_region, merged_pages;
   logic [IDX_W-1:0]   merge_t;
   logic [1:0]         merge_r;
   logic [32:0]        need_sum;

   assign ridx       = cmd.idx[IDX_W-1:0];
   assign cur_start  = start_ff[ridx];
   assign cur_pages  = pages_ff[ridx];
   assign cur_free   = free_ff[ridx];
   assign cur_addr   = base_ff + (32'(cur_start) << PAGE_SHIFT);
   assign need_bytes = 32'(need_ff) << PAGE_SHIFT;
   assign need_sum   = {1'b0, req_bytes} + 33'(PAGE_BYTES - 1);

   always_comb begin
      priority if (region_ff == '0) eff_region = PAGES_W'(1);
      else if (region_ff > REGION_MAX) eff_region = REGION_MAX;
      else eff_region = region_ff;
   end

   always_comb begin
      stat.op           = op_ff;
      stat.req_zero     = zero_ff;
      stat.tgt_null     = (tgt_ff == '0);
      stat.at_end       = (cmd.idx >= count_ff);
      stat.split_needed = (NEED_W'(cur_pages) > need_ff);
      stat.table_full   = (count_ff >= CNT_W'(MAX_BLOCKS));
      stat.rsp_busy     = rsp_valid_ff && !rsp_tready;
      unique case (op_ff)
         OP_ALLOC: stat.match = cur_free && (NEED_W'(cur_pages) >= need_ff);
         OP_FREE:  stat.match = !cur_free && (cur_addr == tgt_ff);
         default:  stat.match = (cur_addr == tgt_ff);
      endcase
   end

   // merge of the freed block with free neighbors
   assign merge_t      = prev_free_ff ? found_ff - 1'b1 : found_ff;
   assign merge_r      = {1'b0, prev_free_ff} + {1'b0, next_free_ff};
   assign merged_pages = found_pages_ff + (prev_free_ff ? prev_pages_ff : '0)
                         + (next_free_ff ? next_pages_ff : '0);

   always_comb begin
      start_in     = start_ff;
      pages_in     = pages_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      alloc_tot_in = alloc_tot_ff;
      freed_tot_in = freed_tot_ff;
      raddr_in     = raddr_ff;
      rbytes_in    = rbytes_ff;
      unique case (cmd.code)
         CMD_LOAD: begin
            raddr_in  = '0;
            rbytes_in = '0;
         end
         CMD_ALLOC: begin
            if (stat.split_needed) begin
               for (int k = 0; k < MAX_BLOCKS; k++) begin
                  if (k > int'(ridx) + 1) begin
                     start_in[k] = start_ff[k-1];
                     pages_in[k] = pages_ff[k-1];
                     free_in[k]  = free_ff[k-1];
                  end
               end
               start_in[ridx+1'b1] = cur_start + PAGE_W'(need_ff);
               pages_in[ridx+1'b1] = cur_pages - PAGES_W'(need_ff);
               free_in[ridx+1'b1]  = 1'b1;
               pages_in[ridx]      = PAGES_W'(need_ff);
               count_in            = count_ff + 1'b1;
            end
            free_in[ridx] = 1'b0;
            raddr_in      = cur_addr;
            rbytes_in     = need_bytes[RBYTES_W-1:0];
            alloc_tot_in  = alloc_tot_ff + need_bytes;
         end
         CMD_QUERY: rbytes_in = RBYTES_W'(32'(cur_pages) << PAGE_SHIFT);
         CMD_SAVE_FREE: begin
            rbytes_in    = RBYTES_W'(32'(cur_pages) << PAGE_SHIFT);
            freed_tot_in = freed_tot_ff + (32'(cur_pages) << PAGE_SHIFT);
         end
         CMD_MERGE: begin
            for (int k = 0; k < MAX_BLOCKS; k++) begin
               if (k > int'(merge_t)) begin
                  if (merge_r == 2'd1 && k + 1 < MAX_BLOCKS) begin
                     start_in[k] = start_ff[k+1];
                     pages_in[k] = pages_ff[k+1];
                     free_in[k]  = free_ff[k+1];
                  end else if (merge_r == 2'd2 && k + 2 < MAX_BLOCKS) begin
                     start_in[k] = start_ff[k+2];
                     pages_in[k] = pages_ff[k+2];
                     free_in[k]  = free_ff[k+2];
                  end
               end
            end
            pages_in[merge_t] = merged_pages;
            free_in[merge_t]  = 1'b1;
            count_in          = count_ff - CNT_W'(merge_r);
         end
         CMD_REINIT: begin
            start_in[0] = '0;
            pages_in[0] = eff_region;
            free_in[0]  = 1'b1;
            count_in    = CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      raddr_ff  <= raddr_in;
      rbytes_ff <= rbytes_in;
      if (cmd.code == CMD_LOAD) begin
         op_ff   <= req_opcode;
         need_ff <= need_sum[32:PAGE_SHIFT];
         zero_ff <= (req_bytes == '0);
         tgt_ff  <= req_target;
      end
      if (cmd.code == CMD_STEP) begin
         prev_pages_ff <= cur_pages;
      end
      if (cmd.code == CMD_SAVE_FREE) begin
         found_ff       <= ridx;
         found_pages_ff <= cur_pages;
      end
      if (cmd.code == CMD_SAVE_NEXT) begin
         next_free_ff  <= !stat.at_end && cur_free;
         next_pages_ff <= cur_pages;
      end
      if (cmd.code == CMD_RESULT) begin
         rsp_status_ff <= cmd.status;
         rsp_addr_ff   <= raddr_ff;
         rsp_bytes_ff  <= rbytes_ff;
         rsp_atot_ff   <= alloc_tot_ff;
         rsp_ftot_ff   <= freed_tot_ff;
      end
      if (reset) begin
         start_ff[0]   <= '0;
         pages_ff[0]   <= REGION_MAX;
         free_ff       <= MAX_BLOCKS'(1);
         count_ff      <= CNT_W'(1);
         alloc_tot_ff  <= '0;
         freed_tot_ff  <= '0;
         base_ff       <= BASE_RESET;
         region_ff     <= REGION_MAX;
         rsp_valid_ff  <= 1'b0;
         prev_free_ff  <= 1'b0;
      end else begin
         start_ff     <= start_in;
         pages_ff     <= pages_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         alloc_tot_ff <= alloc_tot_in;
         freed_tot_ff <= freed_tot_in;
         if (csr_write && csr_index == CSR_BASE) base_ff <= csr_data;
         if (csr_write && csr_index == CSR_REGION) region_ff <= csr_data[PAGES_W-1:0];
         if (cmd.code == CMD_LOAD) prev_free_ff <= 1'b0;
         else if (cmd.code == CMD_STEP) prev_free_ff <= cur_free;
         if (cmd.code == CMD_RESULT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_address     = rsp_addr_ff;
   assign rsp_bytes       = rsp_bytes_ff;
   assign rsp_alloc_total = rsp_atot_ff;
   assign rsp_freed_total = rsp_ftot_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count out of range");
   a_first_start: assert property (@(posedge clock) disable iff (reset)
      start_ff[0] == '0)
      else $error("first block does not start the region");
   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_ALLOC && stat.split_needed |=> count_ff == $past(count_ff) + 1'b1)
      else $error("split did not add an entry");
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_RESULT |-> !rsp_valid_ff || rsp_tready)
      else $error("response overwritten before taken");
endmodule
`default_nettype wire

[hdl/first_fit_region_allocator.sv]
// top level of the first-fit region allocator with coalescing
//
// channel  direction  handshake           payload
// req      in         req_tvalid/tready   tuser opcode, tdata request and target
// rsp      out        rsp_tvalid/tready   tuser status, tdata address, bytes, totals
// csr      in         csr_valid/ready     csr_index, csr_data (always ready)
//
// one command at a time: the request is latched and then decoded, the first-fit
// scan checks one table entry per cycle up to the match, a free adds neighbor
// save and merge steps, and the finish step loads the response register
// reset clears the table to one free block covering the region
// a stalled response holds the finish step; a new beat is taken once done
`default_nettype none
module first_fit_region_allocator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // request_bytes, target_address
   input  wire logic [1:0]   req_tuser,   // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // result_address, result_bytes,
                                          // allocated_total, freed_total, zero pad
   output logic [2:0]        rsp_tuser,   // status
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import ffra_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [31:0]         rsp_address, rsp_alloc_total, rsp_freed_total;
   logic [RBYTES_W-1:0] rsp_bytes;

   // config writes are always taken
   assign csr_ready = 1'b1;

   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffra_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_tuser),
      .req_bytes       (req_tdata[31:0]),
      .req_target      (req_tdata[63:32]),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_address     (rsp_address),
      .rsp_bytes       (rsp_bytes),
      .rsp_alloc_total (rsp_alloc_total),
      .rsp_freed_total (rsp_freed_total)
   );

   // pack the response beat, lowest field first
   assign rsp_tdata = {3'b000, rsp_freed_total, rsp_alloc_total, rsp_bytes, rsp_address};
endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench of the first-fit region allocator: scoreboard, drivers and test phases
`timescale 1ns / 100ps
module tb_top;
   import ffra_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [28:0] nbytes;
      logic [31:0] alloc_tot;
      logic [31:0] free_tot;
   } alloc_result_type;

   // shadow of the block table; predicts one result per command
   class alloc_scoreboard;
      logic [15:0]   start_pg [MAX_BLOCKS];
      logic [16:0]   num_pg   [MAX_BLOCKS];
      bit            is_free  [MAX_BLOCKS];
      int            count;
      logic [31:0]   alloc_tot, free_tot, base;
      logic [16:0]   region;
      alloc_result_type pending_results [$];
      int            errors;

      function void rebuild();
         for (int k = 0; k < MAX_BLOCKS; k++) begin
            start_pg[k] = '0;
            num_pg[k]   = '0;
            is_free[k]  = 0;
         end
         // region 0 acts as one page, oversized values clamp to the maximum
         if (region == 0) num_pg[0] = 17'd1;
         else if (region > REGION_MAX) num_pg[0] = REGION_MAX;
         else num_pg[0] = region;
         is_free[0] = 1;
         count = 1;
      endfunction

      function void power_on();
         base      = BASE_RESET;
         region    = REGION_MAX;
         alloc_tot = '0;
         free_tot  = '0;
         errors    = 0;
         rebuild();
      endfunction

      function void write_reg(logic [7:0] idx, logic [31:0] val);
         if (idx == CSR_BASE) base = val;
         else if (idx == CSR_REGION) region = val[16:0];
      endfunction

      function logic [31:0] addr_of(int k);
         return base + {start_pg[k], 12'h000};
      endfunction

      function void drop_entry(int idx);
         for (int k = idx; k + 1 < count; k++) begin
            start_pg[k] = start_pg[k+1];
            num_pg[k]   = num_pg[k+1];
            is_free[k]  = is_free[k+1];
         end
         count--;
      endfunction

      // predicts the result of one accepted command
      function void note_command(logic [1:0] op, logic [31:0] req, logic [31:0] tgt);
         alloc_result_type r;
         logic [32:0]   need;
         logic [31:0]   b;
         int            hit, k;
         r.status = ST_OK;
         r.addr   = '0;
         b        = '0;
         hit      = count;
         case (op)
            OP_ALLOC: begin
               if (req == 0) r.status = ST_ZERO;
               else begin
                  need = ({1'b0, req} + 33'd4095) >> 12;
                  for (k = 0; k < count; k++)
                     if (is_free[k] && {16'd0, num_pg[k]} >= need) begin
                        hit = k;
                        break;
                     end
                  if (hit == count) r.status = ST_NOMEM;
                  else if ({16'd0, num_pg[hit]} > need && count >= MAX_BLOCKS)
                     r.status = ST_FULL;
                  else begin
                     if ({16'd0, num_pg[hit]} > need) begin
                        for (k = count; k > hit + 1; k--) begin
                           start_pg[k] = start_pg[k-1];
                           num_pg[k]   = num_pg[k-1];
                           is_free[k]  = is_free[k-1];
                        end
                        start_pg[hit+1] = start_pg[hit] + need[15:0];
                        num_pg[hit+1]   = num_pg[hit] - need[16:0];
                        is_free[hit+1]  = 1;
                        count++;
                        num_pg[hit] = need[16:0];
                     end
                     is_free[hit] = 0;
                     r.addr    = addr_of(hit);
                     b         = {3'd0, num_pg[hit], 12'h000};
                     alloc_tot = alloc_tot + b;
                  end
               end
            end
            OP_FREE: begin
               if (tgt != 0)
                  for (k = 0; k < count; k++)
                     if (!is_free[k] && addr_of(k) == tgt) begin
                        hit = k;
                        break;
                     end
               if (hit == count) r.status = ST_INVALID;
               else begin
                  is_free[hit] = 1;
                  b        = {3'd0, num_pg[hit], 12'h000};
                  free_tot = free_tot + b;
                  // merge every run of free neighbors
                  k = 0;
                  while (k + 1 < count) begin
                     if (is_free[k] && is_free[k+1]) begin
                        num_pg[k] = num_pg[k] + num_pg[k+1];
                        drop_entry(k + 1);
                     end else k++;
                  end
               end
            end
            OP_QUERY: begin
               if (tgt != 0)
                  for (k = 0; k < count; k++)
                     if (addr_of(k) == tgt) begin
                        hit = k;
                        break;
                     end
               if (hit == count) r.status = ST_INVALID;
               else b = {3'd0, num_pg[hit], 12'h000};
            end
            default: rebuild();
         endcase
         r.nbytes    = b[28:0];
         r.alloc_tot = alloc_tot;
         r.free_tot  = free_tot;
         pending_results.push_back(r);
      endfunction

      task report(string what, logic [31:0] want, logic [31:0] got);
         $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
         errors++;
      endtask

      task check_result(logic [2:0] status, logic [127:0] data);
         alloc_result_type e;
         if (pending_results.size() == 0) begin
            report("unexpected beat", 0, status);
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) report("status", e.status, status);
         if (data[31:0] !== e.addr) report("result_address", e.addr, data[31:0]);
         if (data[60:32] !== e.nbytes) report("result_bytes", e.nbytes, data[60:32]);
         if (data[92:61] !== e.alloc_tot) report("allocated_total", e.alloc_tot, data[92:61]);
         if (data[124:93] !== e.free_tot) report("freed_total", e.free_tot, data[124:93]);
         if (data[127:125] !== 3'd0) report("pad bits", 0, data[127:125]);
      endtask

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;    // request_bytes, target_address
   logic [1:0]   req_tuser = '0;    // opcode
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;         // result_address, result_bytes, totals, pad
   logic [2:0]   rsp_tuser;         // status
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   alloc_scoreboard sb = new();

   int send_idle_pct  = 0;   // chance of a sender gap after each beat
   int stall_pct      = 0;   // chance per cycle that the receiver stalls
   bit hold_request   = 0;   // asks the receiver for a long hold-off
   int hold_left      = 0;

   first_fit_region_allocator dut (.*);

   always #5 clock = ~clock;

   // receiver: checks every response beat and picks the next ready value
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      if (hold_request) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // offers one command and leaves valid high unless a gap follows
   task send_cmd(logic [1:0] op, logic [31:0] req, logic [31:0] tgt);
      req_tuser  <= op;
      req_tdata  <= {tgt, req};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_command(op, req, tgt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // sender pause until every response is back, then cover the busy tail
   task drain();
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task write_csr(logic [7:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, val);
   endtask

   // address of a random block, used or any, or a random address when none fits
   function logic [31:0] pick_block(bit used_only);
      int cands [$];
      for (int k = 0; k < sb.count; k++)
         if (!used_only || !sb.is_free[k]) cands.push_back(k);
      if (cands.size() == 0) return $urandom();
      return sb.addr_of(cands[$urandom_range(cands.size() - 1)]);
   endfunction

   task random_cmd(int alloc_pct);
      int          r;
      logic [31:0] v;
      r = $urandom_range(99);
      if (r < alloc_pct) begin
         case ($urandom_range(9))
            0:       v = $urandom();
            1:       v = $urandom_range(1, 8) << 12;   // exact page multiples
            2:       v = 0;
            default: v = $urandom_range(1, 6 * PAGE_BYTES);
         endcase
         send_cmd(OP_ALLOC, v, $urandom());
      end else if (r < alloc_pct + 25) begin
         case ($urandom_range(9))
            0:       v = $urandom();
            1:       v = pick_block(0);               // may be a free block
            2:       v = 0;
            3:       v = pick_block(1) + 32'h1000;     // inside or past a block
            default: v = pick_block(1);
         endcase
         send_cmd(OP_FREE, $urandom(), v);
      end else if (r < 97) begin
         v = ($urandom_range(4) == 0) ? $urandom() : pick_block(0);
         send_cmd(OP_QUERY, $urandom(), v);
      end else send_cmd(OP_REINIT, $urandom(), $urandom());
   endtask

   initial begin
      logic [31:0] a;
      sb.power_on();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: edges of the request, null and unknown addresses, reinit
      send_cmd(OP_ALLOC, 32'd0, 32'd0);
      send_cmd(OP_ALLOC, 32'd1, 32'd0);
      send_cmd(OP_ALLOC, 32'd4096, 32'hFFFF_FFFF);
      send_cmd(OP_ALLOC, 32'd4097, 32'd0);
      send_cmd(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OP_QUERY, 32'd0, BASE_RESET);
      send_cmd(OP_QUERY, 32'd0, 32'd0);
      send_cmd(OP_QUERY, 32'd0, BASE_RESET + 32'h800);
      send_cmd(OP_FREE, 32'd0, 32'd0);
      send_cmd(OP_FREE, 32'd0, 32'hDEAD_B000);
      send_cmd(OP_FREE, 32'd0, BASE_RESET + 32'h1000);
      send_cmd(OP_FREE, 32'd0, BASE_RESET + 32'h1000);   // already free
      send_cmd(OP_FREE, 32'd0, BASE_RESET);              // merges with neighbor
      send_cmd(OP_ALLOC, 32'h1000_0000, 32'd0);          // whole region, more than is free
      send_cmd(OP_ALLOC, 32'd1, 32'd0);                  // one page from the first free block
      send_cmd(OP_REINIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      // region of three pages at the top of the address space
      write_csr(CSR_BASE, 32'hFFFF_E000);
      write_csr(CSR_REGION, 32'd3);
      send_cmd(OP_REINIT, 32'd0, 32'd0);
      send_cmd(OP_ALLOC, 32'd8192, 32'd0);
      send_cmd(OP_ALLOC, 32'd4096, 32'd0);               // wraps past 2^32
      send_cmd(OP_ALLOC, 32'd1, 32'd0);
      send_cmd(OP_FREE, 32'd0, 32'd0);                   // address 0 after wrap is null
      drain();
      write_csr(CSR_REGION, 32'd0);                      // acts as one page
      send_cmd(OP_REINIT, 32'd0, 32'd0);
      send_cmd(OP_ALLOC, 32'd8192, 32'd0);
      drain();

      // random phases with different gap patterns and settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            3: begin send_idle_pct = 25; stall_pct = 25; end
            default: begin send_idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
         endcase
         case (ph)
            0: begin write_csr(CSR_BASE, BASE_RESET); write_csr(CSR_REGION, REGION_MAX); end
            1: begin write_csr(CSR_BASE, $urandom()); write_csr(CSR_REGION, $urandom_range(1, 48)); end
            2: begin write_csr(CSR_BASE, 32'd0); write_csr(CSR_REGION, 32'h1FFFF); end
            3: begin write_csr(CSR_BASE, $urandom() & 32'hFFFF_F000);
                     write_csr(CSR_REGION, $urandom_range(1, 200)); end
            default: begin write_csr(CSR_BASE, 32'hFFFF_FFFF);
                     write_csr(CSR_REGION, $urandom_range(20, 2000)); end
         endcase
         send_cmd(OP_REINIT, $urandom(), $urandom());
         for (int n = 0; n < 220; n++) begin
            if (ph == 0 && n == 100) hold_request = 1;   // block fills up and stalls input
            random_cmd((n % 80 < 50) ? 60 : 35);
         end
         drain();
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule
